>>> design/rwsm_pkg.sv
// shared constants, register indexes and types for the rolling window sum and mean block
package rwsm_pkg;

   localparam int MAX_WINDOW      = 32;
   localparam int SAMPLE_WIDTH    = 32;
   localparam int SLOT_WIDTH      = $clog2(MAX_WINDOW);
   localparam int COUNT_WIDTH     = $clog2(MAX_WINDOW + 1);
   localparam int VALUE_WIDTH     = SAMPLE_WIDTH + SLOT_WIDTH;
   localparam int ENTRY_WIDTH     = SAMPLE_WIDTH + 1;
   localparam int DIV_COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 6;
   localparam int WSIZE_WIDTH     = 6;
   localparam int ALIGN_WIDTH     = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_SIZE  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AVERAGE_MODE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALIGNMENT    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAD_ENABLE   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SKIP_MISSING = 3'd4;

   localparam logic [ALIGN_WIDTH-1:0] ALIGN_MID  = 2'd0;
   localparam logic [ALIGN_WIDTH-1:0] ALIGN_HEAD = 2'd1;

   localparam logic [WSIZE_WIDTH-1:0] WSIZE_RESET = 6'd3;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } ring_ctrl_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] total;
      logic [COUNT_WIDTH-1:0]        present;
      logic [COUNT_WIDTH-1:0]        missing;
      logic                          full;
      logic                          first;
   } ring_status_type;

endpackage

>>> design/rolling_window_sum_mean_top.sv
// top level: configuration registers, transaction sequencer and result register
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_stall    req_sample, req_sample_missing, req_end_of_sequence
//   rsp      out  rsp_valid/rsp_stall    rsp_value, rsp_value_missing, rsp_last_of_run
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// one sample per transaction: ring read on acceptance, write-back in ST_UPD, decision
// in ST_RES, window mean in the one-bit-per-cycle divider (ST_DIV), then each result
// (padding included) loaded one per cycle while rsp is not stalled; req_stall stays
// high from acceptance until the last result is loaded, or through ST_RES if the window
// is not full; synchronous reset restores register defaults and empties the window
module rolling_window_sum_mean_top (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [rwsm_pkg::SAMPLE_WIDTH-1:0]    req_sample,
   input  logic                                        req_sample_missing,
   input  logic                                        req_end_of_sequence,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [rwsm_pkg::VALUE_WIDTH-1:0]     rsp_value,
   output logic                                        rsp_value_missing,
   output logic                                        rsp_last_of_run,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [rwsm_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [rwsm_pkg::CSR_DATA_WIDTH-1:0]         csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_UPD  = 3'd1;
   localparam logic [2:0] ST_RES  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;

   logic [rwsm_pkg::WSIZE_WIDTH-1:0] window_size_ff;
   logic                             average_mode_ff;
   logic [rwsm_pkg::ALIGN_WIDTH-1:0] alignment_ff;
   logic                             pad_enable_ff;
   logic                             skip_missing_ff;
   logic                             csr_write;

   logic signed [rwsm_pkg::SAMPLE_WIDTH-1:0] sample_ff;
   logic                                     missing_ff;
   logic                                     eos_ff;

   logic signed [rwsm_pkg::VALUE_WIDTH-1:0] res_val_ff;
   logic                                    res_miss_ff;
   logic [rwsm_pkg::COUNT_WIDTH-1:0]        lead_cnt_ff;
   logic [rwsm_pkg::COUNT_WIDTH-1:0]        trail_cnt_ff;
   logic                                    main_pending_ff;

   logic                                    rsp_valid_ff;
   logic signed [rwsm_pkg::VALUE_WIDTH-1:0] rsp_value_ff;
   logic                                    rsp_value_missing_ff;
   logic                                    rsp_last_of_run_ff;

   logic [rwsm_pkg::COUNT_WIDTH-1:0]        k;
   logic [rwsm_pkg::COUNT_WIDTH-1:0]        start_pos;
   logic [rwsm_pkg::COUNT_WIDTH-1:0]        k_minus_one;
   logic                                    accept;
   logic                                    out_free;
   logic                                    base_miss;
   logic                                    need_div;
   logic                                    final_load;
   logic                                    total_neg;
   logic [rwsm_pkg::VALUE_WIDTH-1:0]        total_mag;

   rwsm_pkg::ring_ctrl_type   ring_ctrl;
   rwsm_pkg::ring_status_type ring_status;
   logic                                    div_done;
   logic [rwsm_pkg::VALUE_WIDTH-1:0]        div_quotient;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (window_size_ff == '0) begin
         k = rwsm_pkg::COUNT_WIDTH'(1);
      end else if (rwsm_pkg::COUNT_WIDTH'(window_size_ff) >
                   rwsm_pkg::COUNT_WIDTH'(rwsm_pkg::MAX_WINDOW)) begin
         k = rwsm_pkg::COUNT_WIDTH'(rwsm_pkg::MAX_WINDOW);
      end else begin
         k = rwsm_pkg::COUNT_WIDTH'(window_size_ff);
      end
      k_minus_one = k - 1'b1;
      case (alignment_ff)
         rwsm_pkg::ALIGN_MID:  start_pos = k_minus_one >> 1;
         rwsm_pkg::ALIGN_HEAD: start_pos = '0;
         default:              start_pos = k_minus_one;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff  <= rwsm_pkg::WSIZE_RESET;
         average_mode_ff <= 1'b0;
         alignment_ff    <= '0;
         pad_enable_ff   <= 1'b0;
         skip_missing_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            rwsm_pkg::CSR_WINDOW_SIZE:  window_size_ff  <= csr_data[rwsm_pkg::WSIZE_WIDTH-1:0];
            rwsm_pkg::CSR_AVERAGE_MODE: average_mode_ff <= csr_data[0];
            rwsm_pkg::CSR_ALIGNMENT:    alignment_ff    <= csr_data[rwsm_pkg::ALIGN_WIDTH-1:0];
            rwsm_pkg::CSR_PAD_ENABLE:   pad_enable_ff   <= csr_data[0];
            rwsm_pkg::CSR_SKIP_MISSING: skip_missing_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      base_miss  = (ring_status.missing != '0) && !skip_missing_ff;
      need_div   = average_mode_ff && !base_miss && (ring_status.present != '0);
      total_neg  = ring_status.total[rwsm_pkg::VALUE_WIDTH-1];
      total_mag  = total_neg ? -ring_status.total : ring_status.total;
      final_load = (state_ff == ST_EMIT) && out_free && (lead_cnt_ff == '0)
                   && (main_pending_ff ? (trail_cnt_ff == '0)
                                       : (trail_cnt_ff == rwsm_pkg::COUNT_WIDTH'(1)));
   end

   always_comb begin
      ring_ctrl.rd_en = accept;
      ring_ctrl.wr_en = (state_ff == ST_UPD);
      ring_ctrl.clear = (csr_write && (csr_index == rwsm_pkg::CSR_WINDOW_SIZE))
                        || (eos_ff && (((state_ff == ST_RES) && !ring_status.full)
                                       || final_load));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_UPD;
         ST_UPD:  state_in = ST_RES;
         ST_RES: begin
            if (!ring_status.full) begin
               state_in = ST_IDLE;
            end else if (need_div) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV:  if (div_done) state_in = ST_EMIT;
         ST_EMIT: if (final_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff  <= req_sample;
         missing_ff <= req_sample_missing;
         eos_ff     <= req_end_of_sequence;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_pending_ff <= 1'b0;
         lead_cnt_ff     <= '0;
         trail_cnt_ff    <= '0;
      end else if (state_ff == ST_RES) begin
         main_pending_ff <= 1'b1;
         lead_cnt_ff     <= (ring_status.first && pad_enable_ff) ? start_pos : '0;
         trail_cnt_ff    <= (eos_ff && pad_enable_ff) ? (k_minus_one - start_pos) : '0;
      end else if ((state_ff == ST_EMIT) && out_free) begin
         if (lead_cnt_ff != '0) begin
            lead_cnt_ff <= lead_cnt_ff - 1'b1;
         end else if (main_pending_ff) begin
            main_pending_ff <= 1'b0;
         end else if (trail_cnt_ff != '0) begin
            trail_cnt_ff <= trail_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RES) begin
         res_miss_ff <= base_miss || (average_mode_ff && (ring_status.present == '0));
         res_val_ff  <= (average_mode_ff || base_miss) ? '0 : ring_status.total;
      end else if ((state_ff == ST_DIV) && div_done) begin
         res_val_ff <= total_neg ? -$signed(div_quotient) : $signed(div_quotient);
      end
   end

   rwsm_ring u_ring (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ring_ctrl),
      .k              (k),
      .sample         (sample_ff),
      .sample_missing (missing_ff),
      .status         (ring_status)
   );

   rwsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == ST_RES) && ring_status.full && need_div),
      .dividend (total_mag),
      .divisor  (ring_status.present),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_EMIT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_EMIT) && out_free) begin
         rsp_last_of_run_ff <= final_load;
         if ((lead_cnt_ff == '0) && main_pending_ff) begin
            rsp_value_ff         <= res_miss_ff ? '0 : res_val_ff;
            rsp_value_missing_ff <= res_miss_ff;
         end else begin
            rsp_value_ff         <= '0;
            rsp_value_missing_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_value_missing = rsp_value_missing_ff;
   assign rsp_last_of_run   = rsp_last_of_run_ff;

endmodule

>>> design/rwsm_ring.sv
// sample ring memory with read-modify-write of the running total and window counts
module rwsm_ring (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rwsm_pkg::ring_ctrl_type                ctrl,
   input  logic [rwsm_pkg::COUNT_WIDTH-1:0]       k,
   input  logic signed [rwsm_pkg::SAMPLE_WIDTH-1:0] sample,
   input  logic                                   sample_missing,
   output rwsm_pkg::ring_status_type              status
);

   logic [rwsm_pkg::ENTRY_WIDTH-1:0] mem [rwsm_pkg::MAX_WINDOW];
   logic [rwsm_pkg::ENTRY_WIDTH-1:0] rd_data_ff;

   logic [rwsm_pkg::SLOT_WIDTH-1:0]          slot_ff, slot_in;
   logic [rwsm_pkg::COUNT_WIDTH-1:0]         seen_ff, seen_in;
   logic signed [rwsm_pkg::VALUE_WIDTH-1:0]  total_ff, total_in;
   logic [rwsm_pkg::COUNT_WIDTH-1:0]         missing_ff, missing_in;
   logic [rwsm_pkg::COUNT_WIDTH-1:0]         present_ff, present_in;
   logic                                     first_ff, first_in;

   logic                                     full_before;
   logic                                     old_miss;
   logic signed [rwsm_pkg::SAMPLE_WIDTH-1:0] old_val;
   logic signed [rwsm_pkg::VALUE_WIDTH-1:0]  sub_val;
   logic signed [rwsm_pkg::VALUE_WIDTH-1:0]  add_val;
   logic [rwsm_pkg::COUNT_WIDTH-1:0]         slot_next;
   logic [rwsm_pkg::COUNT_WIDTH-1:0]         seen_next;
   logic                                     miss_dec;
   logic                                     pres_dec;

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[slot_ff];
      end
      if (ctrl.wr_en) begin
         mem[slot_ff] <= {sample_missing,
                          sample_missing ? {rwsm_pkg::SAMPLE_WIDTH{1'b0}} : sample};
      end
   end

   always_comb begin
      full_before = (seen_ff >= k);
      old_miss    = rd_data_ff[rwsm_pkg::SAMPLE_WIDTH];
      old_val     = rd_data_ff[rwsm_pkg::SAMPLE_WIDTH-1:0];
      sub_val     = (full_before && !old_miss) ?
                    rwsm_pkg::VALUE_WIDTH'(old_val) : '0;
      add_val     = sample_missing ? '0 : rwsm_pkg::VALUE_WIDTH'(sample);
      total_in    = total_ff - sub_val + add_val;
      miss_dec    = full_before && old_miss && (missing_ff != '0);
      pres_dec    = full_before && !old_miss && (present_ff != '0);
      missing_in  = missing_ff - rwsm_pkg::COUNT_WIDTH'(miss_dec)
                    + rwsm_pkg::COUNT_WIDTH'(sample_missing);
      present_in  = present_ff - rwsm_pkg::COUNT_WIDTH'(pres_dec)
                    + rwsm_pkg::COUNT_WIDTH'(!sample_missing);
      slot_next   = rwsm_pkg::COUNT_WIDTH'(slot_ff) + 1'b1;
      slot_in     = (slot_next >= k) ? '0 : slot_next[rwsm_pkg::SLOT_WIDTH-1:0];
      seen_next   = seen_ff + 1'b1;
      seen_in     = full_before ? seen_ff : seen_next;
      first_in    = !full_before && (seen_next == k);
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         slot_ff    <= '0;
         seen_ff    <= '0;
         total_ff   <= '0;
         missing_ff <= '0;
         present_ff <= '0;
         first_ff   <= 1'b0;
      end else if (ctrl.wr_en) begin
         slot_ff    <= slot_in;
         seen_ff    <= seen_in;
         total_ff   <= total_in;
         missing_ff <= missing_in;
         present_ff <= present_in;
         first_ff   <= first_in;
      end
   end

   assign status.total   = total_ff;
   assign status.present = present_ff;
   assign status.missing = missing_ff;
   assign status.full    = (seen_ff == k);
   assign status.first   = first_ff;

endmodule

>>> design/rwsm_div.sv
// radix-2 restoring divider of the window total magnitude by the present count
module rwsm_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [rwsm_pkg::VALUE_WIDTH-1:0]     dividend,
   input  logic [rwsm_pkg::COUNT_WIDTH-1:0]     divisor,
   output logic                                 done,
   output logic [rwsm_pkg::VALUE_WIDTH-1:0]     quotient
);

   logic                                    busy_ff;
   logic                                    done_ff;
   logic [rwsm_pkg::DIV_COUNT_WIDTH-1:0]    cnt_ff;
   logic [rwsm_pkg::VALUE_WIDTH-1:0]        quo_ff;
   logic [rwsm_pkg::COUNT_WIDTH-1:0]        rem_ff;
   logic [rwsm_pkg::COUNT_WIDTH-1:0]        divisor_ff;
   logic [rwsm_pkg::COUNT_WIDTH:0]          trial;
   logic                                    fits;

   always_comb begin
      trial = {rem_ff, quo_ff[rwsm_pkg::VALUE_WIDTH-1]};
      fits  = (trial >= {1'b0, divisor_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == rwsm_pkg::DIV_COUNT_WIDTH'(rwsm_pkg::VALUE_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[rwsm_pkg::VALUE_WIDTH-2:0], fits};
         rem_ff <= fits ? rwsm_pkg::COUNT_WIDTH'(trial - {1'b0, divisor_ff})
                        : trial[rwsm_pkg::COUNT_WIDTH-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
